### rtl/h264_access_unit_splitter_macros.svh
// Assertion helpers used by the top-level file of this block.
`ifndef H264_ACCESS_UNIT_SPLITTER_MACROS_SVH
`define H264_ACCESS_UNIT_SPLITTER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define AUS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("access unit splitter check failed");

// Next-cycle implication, checked outside reset
`define AUS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("access unit splitter check failed");

`endif

### rtl/h264aus_pkg.sv
`timescale 1ns / 1ps

package h264aus_pkg;

    // Width of the internal byte position counters
    localparam int OFFSET_BITS = 32;

    localparam int BYTE_BITS  = 8;
    localparam int FIELD_BITS = 32;
    localparam int TIME_BITS  = 64;

    // Configuration port
    localparam int CFG_DATA_BITS = 31;
    localparam int CFG_IDX_BITS  = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATE_NUM = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATE_DEN = 1'd1;
    localparam logic [CFG_DATA_BITS-1:0] RATE_NUM_RESET = 31'd30;
    localparam logic [CFG_DATA_BITS-1:0] RATE_DEN_RESET = 31'd1;

    // NAL header fields and types
    localparam logic [7:0] NAL_KIND_MASK = 8'h1F;
    localparam logic [7:0] FIRST_MB_BIT  = 8'h80;
    localparam logic [7:0] START_CODE_END = 8'h01;
    localparam logic [4:0] NAL_SLICE_FIRST = 5'd1;
    localparam logic [4:0] NAL_SLICE_LAST  = 5'd5;
    localparam logic [4:0] NAL_SEI = 5'd6;
    localparam logic [4:0] NAL_PPS = 5'd8;
    localparam logic [4:0] NAL_AUD = 5'd9;

    // Time arithmetic
    localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
    localparam int DIV_STEPS    = TIME_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // Unit queue between scanner and timer
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    typedef logic [OFFSET_BITS-1:0] t_pos;

    typedef struct packed {
        logic [FIELD_BITS-1:0] unit_offset;
        logic [FIELD_BITS-1:0] unit_length;
        logic [FIELD_BITS-1:0] unit_number;
        logic                  unit_is_final;
    } t_unit_rec;

    // Up to two closed units per byte; second valid only with the first
    typedef struct packed {
        logic      valid0;
        logic      valid1;
        t_unit_rec rec0;
        t_unit_rec rec1;
    } t_push;

    typedef struct packed {
        logic      valid;
        t_unit_rec rec;
    } t_q_head;

    typedef struct packed {
        logic                  room;
        logic [Q_CNT_BITS-1:0] count;
    } t_q_status;

endpackage

### rtl/h264aus_if.sv
`timescale 1ns / 1ps

// Byte stream channel
interface h264aus_in_if;
    import h264aus_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 end_of_stream;

    modport source (output valid, data_byte, end_of_stream, input ready);
    modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

// Access unit result channel
interface h264aus_out_if;
    import h264aus_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [FIELD_BITS-1:0]       unit_offset;
    logic [FIELD_BITS-1:0]       unit_length;
    logic [FIELD_BITS-1:0]       unit_number;
    logic signed [TIME_BITS-1:0] unit_time_ns;
    logic                        unit_is_final;

    modport source (output valid, unit_offset, unit_length, unit_number, unit_time_ns,
                    unit_is_final, input ready);
    modport sink   (input valid, unit_offset, unit_length, unit_number, unit_time_ns,
                    unit_is_final, output ready);
endinterface

### rtl/h264aus_scanner.sv
`timescale 1ns / 1ps

module h264aus_scanner (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    h264aus_in_if.sink             i_in,
    input  h264aus_pkg::t_q_status i_q_stat,
    output h264aus_pkg::t_push     o_push
);
    import h264aus_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SLICE
    } t_phase;

    t_phase      r_phase, n_phase;
    t_pos        r_pos, n_pos;
    t_pos        r_ustart, n_ustart;
    t_pos        r_pend, n_pend;
    t_pos        r_earliest, n_earliest;
    logic [23:0] r_recent, n_recent;
    logic        r_open, n_open;
    logic        r_pic, n_pic;
    logic [FIELD_BITS-1:0] r_count, n_count;
    logic        w_accept;
    t_push       w_push;

    assign i_in.ready = i_q_stat.room;
    assign w_accept   = i_in.valid && i_q_stat.room;
    assign o_push     = w_push;

    // Next state for one accepted byte
    always_comb begin
        logic [4:0] kind;
        logic       leading, slice_kind, cut, e0, e1;
        t_pos       code_gap, c, pos1;
        t_unit_rec  rec0, rec1;

        n_phase    = r_phase;
        n_pos      = r_pos;
        n_ustart   = r_ustart;
        n_pend     = r_pend;
        n_earliest = r_earliest;
        n_recent   = r_recent;
        n_open     = r_open;
        n_pic      = r_pic;
        e0         = 1'b0;
        cut        = 1'b0;
        kind       = 5'(i_in.data_byte & NAL_KIND_MASK);
        leading    = (r_pend == r_ustart);
        slice_kind = (kind >= NAL_SLICE_FIRST) && (kind <= NAL_SLICE_LAST);
        code_gap   = r_pos - r_earliest;
        c          = r_pos - t_pos'(2);
        pos1       = r_pos + t_pos'(1);

        case (r_phase)
            PH_HEADER: begin
                n_phase = PH_IDLE;
                if (!leading) begin
                    cut = (kind == NAL_AUD) ||
                          (r_pic && (kind >= NAL_SEI) && (kind <= NAL_PPS));
                end
                if (cut) begin
                    e0       = 1'b1;
                    n_ustart = r_pend;
                    n_pic    = 1'b0;
                end
                if (slice_kind) begin
                    if (!leading && r_pic) begin
                        n_phase = PH_SLICE;
                    end else begin
                        n_pic = 1'b1;
                    end
                end
            end
            PH_SLICE: begin
                n_phase = PH_IDLE;
                if ((i_in.data_byte & FIRST_MB_BIT) != 8'd0) begin
                    e0       = 1'b1;
                    n_ustart = r_pend;
                end
                n_pic = 1'b1;
            end
            default: begin
                // start code search; codes may not overlap the last header
                if (i_in.data_byte == START_CODE_END && r_recent[15:0] == 16'd0 &&
                    code_gap >= t_pos'(2)) begin
                    if (code_gap >= t_pos'(3) && r_recent[23:16] == 8'd0) begin
                        c = r_pos - t_pos'(3);
                    end
                    if (!r_open) begin
                        n_open   = 1'b1;
                        n_ustart = c;
                        n_pic    = 1'b0;
                    end
                    n_pend     = c;
                    n_earliest = r_pos + t_pos'(2);
                    n_phase    = PH_HEADER;
                end
            end
        endcase

        n_recent = {r_recent[15:0], i_in.data_byte};
        n_pos    = pos1;

        // unit closed by a boundary NAL
        rec0.unit_offset   = FIELD_BITS'(r_ustart);
        rec0.unit_length   = FIELD_BITS'(r_pend - r_ustart);
        rec0.unit_number   = r_count;
        rec0.unit_is_final = 1'b0;

        // unit closed by end of stream
        e1                 = i_in.end_of_stream && n_open;
        rec1.unit_offset   = FIELD_BITS'(n_ustart);
        rec1.unit_length   = FIELD_BITS'(pos1 - n_ustart);
        rec1.unit_number   = r_count + FIELD_BITS'(e0);
        rec1.unit_is_final = 1'b1;

        n_count = r_count + FIELD_BITS'(e0) + FIELD_BITS'(e1);

        if (i_in.end_of_stream) begin
            n_phase    = PH_IDLE;
            n_pos      = '0;
            n_ustart   = '0;
            n_pend     = '0;
            n_earliest = '0;
            n_recent   = 24'hFFFFFF;
            n_open     = 1'b0;
            n_pic      = 1'b0;
            n_count    = '0;
        end

        // pack so that a lone result always sits in the first slot
        if (e0) begin
            w_push.valid0 = w_accept;
            w_push.valid1 = w_accept && e1;
            w_push.rec0   = rec0;
            w_push.rec1   = rec1;
        end else begin
            w_push.valid0 = w_accept && e1;
            w_push.valid1 = 1'b0;
            w_push.rec0   = rec1;
            w_push.rec1   = rec1;
        end
    end

    // Scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pos      <= '0;
            r_ustart   <= '0;
            r_pend     <= '0;
            r_earliest <= '0;
            r_recent   <= 24'hFFFFFF;
            r_open     <= 1'b0;
            r_pic      <= 1'b0;
            r_count    <= '0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_ustart   <= n_ustart;
            r_pend     <= n_pend;
            r_earliest <= n_earliest;
            r_recent   <= n_recent;
            r_open     <= n_open;
            r_pic      <= n_pic;
            r_count    <= n_count;
        end
    end

endmodule

### rtl/h264aus_queue.sv
`timescale 1ns / 1ps

module h264aus_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  h264aus_pkg::t_push     i_push,
    input  logic                   i_pop,
    output h264aus_pkg::t_q_head   o_head,
    output h264aus_pkg::t_q_status o_stat
);
    import h264aus_pkg::*;

    t_unit_rec             r_mem [QUEUE_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr, n_wr;
    logic [Q_PTR_BITS-1:0] r_rd, n_rd;
    logic [Q_CNT_BITS-1:0] r_count, n_count;
    logic                  w_pop;
    logic [Q_PTR_BITS-1:0] w_wr1;

    assign w_pop  = i_pop && (r_count != '0);
    assign w_wr1  = r_wr + Q_PTR_BITS'(1);

    assign o_head.valid = (r_count != '0);
    assign o_head.rec   = r_mem[r_rd];
    // room for the two results a single byte may close
    assign o_stat.room  = (r_count <= Q_CNT_BITS'(QUEUE_DEPTH - 2));
    assign o_stat.count = r_count;

    // Pointer and fill updates
    always_comb begin
        n_wr    = r_wr + Q_PTR_BITS'(i_push.valid0) + Q_PTR_BITS'(i_push.valid1);
        n_rd    = r_rd + Q_PTR_BITS'(w_pop);
        n_count = r_count + Q_CNT_BITS'(i_push.valid0) + Q_CNT_BITS'(i_push.valid1)
                  - Q_CNT_BITS'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_mem[r_wr] <= i_push.rec0;
        end
        if (i_push.valid1) begin
            r_mem[w_wr1] <= i_push.rec1;
        end
    end

endmodule

### rtl/h264aus_timer.sv
`timescale 1ns / 1ps

module h264aus_timer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  h264aus_pkg::t_q_head                   i_head,
    output logic                                   o_pop,
    input  logic [h264aus_pkg::CFG_DATA_BITS-1:0]  i_rate_num,
    input  logic [h264aus_pkg::CFG_DATA_BITS-1:0]  i_rate_den,
    h264aus_out_if.source                          o_out
);
    import h264aus_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_SIGN,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state                  r_state;
    t_unit_rec               r_job;
    logic [TIME_BITS-1:0]    r_acc;
    logic [TIME_BITS-1:0]    r_lo;
    logic [31:0]             r_hi;
    logic                    r_neg;
    logic [TIME_BITS-1:0]    r_quo;
    logic [CFG_DATA_BITS-1:0] r_rem;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic                    r_out_valid;
    t_unit_rec               r_out;
    logic [TIME_BITS-1:0]    r_time;

    logic [31:0]             w_mul_a, w_mul_b;
    logic [63:0]             w_prod;
    logic [TIME_BITS-1:0]    w_full;
    logic [CFG_DATA_BITS:0]  w_shift;
    logic                    w_ge;
    logic                    w_load;
    logic [TIME_BITS-1:0]    w_time;

    // Shared 32x32 multiplier
    always_comb begin
        case (r_state)
            ST_MUL0: begin
                w_mul_a = r_job.unit_number;
                w_mul_b = NS_PER_SEC;
            end
            ST_MUL1: begin
                w_mul_a = r_acc[31:0];
                w_mul_b = 32'(i_rate_den);
            end
            ST_MUL2: begin
                w_mul_a = r_acc[63:32];
                w_mul_b = 32'(i_rate_den);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_prod = w_mul_a * w_mul_b;

    // Wrapped 64-bit product from the two partial products
    assign w_full = {r_lo[63:32] + r_hi, r_lo[31:0]};

    // One restoring division step
    assign w_shift = {r_rem, r_quo[TIME_BITS-1]};
    assign w_ge    = (w_shift >= {1'b0, i_rate_num});

    assign w_time = (i_rate_num == '0) ? '0 : (r_neg ? (~r_quo + 64'd1) : r_quo);
    assign w_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
    assign o_pop  = (r_state == ST_IDLE) && i_head.valid;

    assign o_out.valid         = r_out_valid;
    assign o_out.unit_offset   = r_out.unit_offset;
    assign o_out.unit_length   = r_out.unit_length;
    assign o_out.unit_number   = r_out.unit_number;
    assign o_out.unit_is_final = r_out.unit_is_final;
    assign o_out.unit_time_ns  = r_time;

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out       <= r_job;
                r_time      <= w_time;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_job   <= i_head.rec;
                        r_state <= ST_MUL0;
                    end
                end
                ST_MUL0: begin
                    r_acc   <= w_prod;
                    r_state <= ST_MUL1;
                end
                ST_MUL1: begin
                    r_lo    <= w_prod;
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_hi    <= w_prod[31:0];
                    r_state <= ST_SIGN;
                end
                ST_SIGN: begin
                    // divide the magnitude, restore the sign at the end
                    r_neg   <= w_full[TIME_BITS-1];
                    r_quo   <= w_full[TIME_BITS-1] ? (~w_full + 64'd1) : w_full;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem   <= w_ge ? CFG_DATA_BITS'(w_shift - {1'b0, i_rate_num})
                                    : CFG_DATA_BITS'(w_shift);
                    r_quo   <= {r_quo[TIME_BITS-2:0], w_ge};
                    r_cnt   <= r_cnt + DIV_CNT_BITS'(1);
                    if (r_cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/h264_access_unit_splitter.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                                        Handshake
// i_in      in   data_byte[7:0], end_of_stream                  valid/ready
// o_out     out  unit_offset, unit_length, unit_number,         valid/ready
//                unit_time_ns (signed 64), unit_is_final
// i_cfg_*   in   i_cfg_idx, i_cfg_data[30:0]                    i_cfg_we
//
// The scanner takes one byte per cycle while the unit queue has two free slots.
// Each closed unit then passes through the timer: three multiplier
// passes, a sign step, 64 steps of the bit-serial divider and a hand-over.
// Reset is synchronous, active low; the rate registers return to 30/1.
// A stalled output holds its item and stops the timer after its next unit.
module h264_access_unit_splitter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    h264aus_in_if.sink                            i_in,
    h264aus_out_if.source                         o_out,
    input  logic                                  i_cfg_we,
    input  logic [h264aus_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [h264aus_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import h264aus_pkg::*;
    `include "h264_access_unit_splitter_macros.svh"

    logic [CFG_DATA_BITS-1:0] r_rate_num;
    logic [CFG_DATA_BITS-1:0] r_rate_den;
    t_push     w_push;
    t_q_head   w_head;
    t_q_status w_q_stat;
    logic      w_pop;

    // Rate registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_num <= RATE_NUM_RESET;
            r_rate_den <= RATE_DEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATE_NUM: r_rate_num <= i_cfg_data;
                CFG_RATE_DEN: r_rate_den <= i_cfg_data;
                default: ;
            endcase
        end
    end

    h264aus_scanner u_scanner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push)
    );

    h264aus_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    h264aus_timer u_timer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .i_rate_num (r_rate_num),
        .i_rate_den (r_rate_den),
        .o_out      (o_out)
    );

    // Results are only produced by accepted bytes
    `AUS_ASSERT_NOW(a_push_on_accept, i_clk, i_rst_n, w_push.valid0, i_in.valid && i_in.ready)
    // A second result never arrives without the first slot filled
    `AUS_ASSERT_NOW(a_push_packed, i_clk, i_rst_n, w_push.valid1, w_push.valid0)
    // Queue never holds more than its depth
    `AUS_ASSERT_NEXT(a_queue_bound, i_clk, i_rst_n, 1'b1, w_q_stat.count <= Q_CNT_BITS'(QUEUE_DEPTH))

endmodule

### sim/tb_h264_access_unit_splitter.sv
`timescale 1ns / 1ps

module tb_h264_access_unit_splitter;
    import h264aus_pkg::*;

    localparam logic [4:0]  NAL_SPS         = 5'd7;
    localparam logic [30:0] RATE_MAX        = 31'h7FFF_FFFF;
    localparam int          MAX_REPORTS     = 10;
    localparam int          DRAIN_CYCLES    = 300;
    localparam int          BYTES_PER_PHASE = 155;
    localparam int          NUM_SETTINGS    = 6;
    localparam int          NUM_FIXED       = 4;

    // Fixed rate settings; the remaining phases pick random rates
    localparam logic [30:0] FIXED_NUM [NUM_FIXED] = '{31'd1, RATE_MAX, RATE_MAX, 31'd1};
    localparam logic [30:0] FIXED_DEN [NUM_FIXED] = '{RATE_MAX, 31'd1, RATE_MAX, 31'd1};

    // Opening stream {end_of_stream, byte}: leading byte, 4-byte code with AUD
    // as first NAL, IDR slice, slice with first_mb zero, SEI after picture,
    // AUD on the last byte (two units), then a lone end with no unit open.
    localparam logic [8:0] OPENING_SEQ [25] = '{
        9'h0FF, 9'h000, 9'h000, 9'h000, 9'h001, 9'h009, 9'h000, 9'h000, 9'h001,
        9'h065, 9'h088, 9'h000, 9'h000, 9'h001, 9'h041, 9'h09A, 9'h000, 9'h000,
        9'h001, 9'h006, 9'h000, 9'h000, 9'h001, 9'h109, 9'h1FF
    };

    typedef enum logic [1:0] {HDR_IDLE, HDR_NAL, HDR_SLICE} t_hdr_phase;
    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_SLOW} t_sink_mode;

    typedef struct packed {
        logic       eos;
        logic [7:0] data;
    } t_stream_byte;

    typedef struct {
        logic [31:0] offset;
        logic [31:0] length;
        logic [31:0] number;
        logic [63:0] time_ns;
        logic        is_final;
    } t_access_unit;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    h264aus_in_if  in_if ();
    h264aus_out_if out_if ();

    h264_access_unit_splitter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stimulus and expected units
    t_stream_byte stream_bytes [$];
    t_access_unit due_units [$];
    int           queued_bytes = 0;
    int           mismatches   = 0;
    bit           in_pending   = 1'b0;

    // Predictor copy of the rate registers
    logic [30:0] rate_num;
    logic [30:0] rate_den;

    // Predictor copy of the scanner state
    logic [31:0] pos_count;
    logic [23:0] last_three;
    logic        unit_open;
    logic [31:0] unit_base;
    logic        pic_seen;
    t_hdr_phase  hdr_phase;
    logic [31:0] nal_code_at;
    logic [31:0] next_code_min;
    logic [31:0] units_closed;

    // Sender and receiver pacing
    int         burst_left = 0;
    int         gap_left   = 0;
    int         sink_left  = 0;
    int         sink_tick  = 0;
    t_sink_mode sink_mode  = SINK_OPEN;

    function automatic void clear_scanner();
        pos_count     = '0;
        last_three    = 24'hFF_FFFF;
        unit_open     = 1'b0;
        unit_base     = '0;
        pic_seen      = 1'b0;
        hdr_phase     = HDR_IDLE;
        nal_code_at   = '0;
        next_code_min = '0;
        units_closed  = '0;
    endfunction

    // Wrapping 64-bit product, then signed division truncating toward zero
    function automatic logic [63:0] unit_time(input logic [31:0] number);
        logic [63:0] prod;
        logic [63:0] mag;
        logic [63:0] quot;
        if (rate_num == '0) return '0;
        prod = 64'(number) * 64'(NS_PER_SEC) * 64'(rate_den);
        mag  = prod[63] ? -prod : prod;
        quot = mag / 64'(rate_num);
        return prod[63] ? -quot : quot;
    endfunction

    function automatic void close_unit(input logic [31:0] end_pos, input logic is_final);
        t_access_unit u;
        u.offset   = unit_base;
        u.length   = end_pos - unit_base;
        u.number   = units_closed;
        u.time_ns  = unit_time(units_closed);
        u.is_final = is_final;
        due_units.push_back(u);
        units_closed++;
    endfunction

    // One accepted byte through the scanner
    function automatic void scan_byte(input logic [7:0] b, input logic eos);
        logic [4:0]  kind;
        logic        leading;
        logic        slice_kind;
        logic        cut;
        logic [31:0] code_gap;
        logic [31:0] code_at;
        case (hdr_phase)
            HDR_NAL: begin
                kind       = 5'(b & NAL_KIND_MASK);
                leading    = (nal_code_at == unit_base);
                slice_kind = (kind >= NAL_SLICE_FIRST) && (kind <= NAL_SLICE_LAST);
                cut        = !leading && ((kind == NAL_AUD) ||
                             (pic_seen && kind >= NAL_SEI && kind <= NAL_PPS));
                hdr_phase = HDR_IDLE;
                if (cut) begin
                    close_unit(nal_code_at, 1'b0);
                    unit_base = nal_code_at;
                    pic_seen  = 1'b0;
                end
                if (slice_kind) begin
                    if (!leading && pic_seen) hdr_phase = HDR_SLICE;
                    else pic_seen = 1'b1;
                end
            end
            HDR_SLICE: begin
                hdr_phase = HDR_IDLE;
                if ((b & FIRST_MB_BIT) != '0) begin
                    close_unit(nal_code_at, 1'b0);
                    unit_base = nal_code_at;
                end
                pic_seen = 1'b1;
            end
            default: begin
                if (b == START_CODE_END && last_three[15:0] == 16'h0000) begin
                    code_gap = pos_count - next_code_min;
                    if (code_gap >= 2) begin
                        code_at = pos_count - 2;
                        if (code_gap >= 3 && last_three[23:16] == 8'h00) code_at = pos_count - 3;
                        if (!unit_open) begin
                            unit_open = 1'b1;
                            unit_base = code_at;
                            pic_seen  = 1'b0;
                        end
                        nal_code_at   = code_at;
                        next_code_min = pos_count + 2;
                        hdr_phase     = HDR_NAL;
                    end
                end
            end
        endcase
        last_three = {last_three[15:0], b};
        pos_count  = pos_count + 1;
        if (eos) begin
            if (unit_open) close_unit(pos_count, 1'b1);
            clear_scanner();
        end
    endfunction

    function automatic void push_byte(input logic eos, input logic [7:0] data);
        stream_bytes.push_back('{eos: eos, data: data});
        queued_bytes++;
    endfunction

    // Mostly well-formed streams of NALs with random content, some noise
    function automatic void queue_streams(input int n_bytes);
        int         goal;
        int         n_nal;
        int         n_pay;
        int         pick;
        logic [4:0] kind;
        logic       is_last;
        logic       done;
        goal = queued_bytes + n_bytes;
        while (queued_bytes < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise, heavy in zeros and ones
                n_pay = $urandom_range(1, 24);
                for (int i = 0; i < n_pay; i++) begin
                    pick = $urandom_range(0, 7);
                    push_byte(i == n_pay - 1, (pick < 3) ? 8'h00 :
                              (pick == 3) ? START_CODE_END : 8'($urandom));
                end
            end else begin
                for (int i = $urandom_range(0, 3); i > 0; i--) push_byte(1'b0, 8'($urandom));
                n_nal = $urandom_range(1, 10);
                done  = 1'b0;
                for (int k = 0; k < n_nal && !done; k++) begin
                    is_last = (k == n_nal - 1);
                    if ($urandom_range(0, 3) == 0) push_byte(1'b0, 8'h00);
                    if ($urandom_range(0, 15) == 0) push_byte(1'b0, 8'h00);
                    push_byte(1'b0, 8'h00);
                    push_byte(1'b0, 8'h00);
                    push_byte(1'b0, START_CODE_END);
                    pick = $urandom_range(0, 99);
                    if (pick < 15)      kind = NAL_AUD;
                    else if (pick < 22) kind = NAL_SEI;
                    else if (pick < 28) kind = NAL_SPS;
                    else if (pick < 34) kind = NAL_PPS;
                    else if (pick < 85) kind = 5'($urandom_range(NAL_SLICE_FIRST, NAL_SLICE_LAST));
                    else                kind = 5'($urandom);
                    // stream may end on the header or on the slice decision byte
                    done = is_last && ($urandom_range(0, 3) == 0);
                    push_byte(done, {1'($urandom_range(0, 15) == 0), 2'($urandom), kind});
                    if (!done && kind >= NAL_SLICE_FIRST && kind <= NAL_SLICE_LAST) begin
                        done = is_last && ($urandom_range(0, 3) == 0);
                        push_byte(done, 8'($urandom));
                    end
                    if (!done) begin
                        n_pay = $urandom_range(0, 6);
                        for (int i = 0; i < n_pay; i++)
                            push_byte(1'b0, ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom));
                    end
                end
                if (!done) push_byte(1'b1, 8'($urandom_range(1, 255)));
            end
        end
    endfunction

    task automatic write_rate(input logic [CFG_IDX_BITS-1:0] idx, input logic [30:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_RATE_NUM) rate_num = value;
        else rate_den = value;
    endtask

    task automatic wait_drained();
        while (stream_bytes.size() != 0 || in_pending || due_units.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Driver: bytes in bursts with gaps, result ready on its own pattern
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_pending) begin
                if (gap_left != 0) begin
                    in_if.valid <= 1'b0;
                    gap_left--;
                end else if (stream_bytes.size() != 0) begin
                    in_if.valid         <= 1'b1;
                    in_if.data_byte     <= stream_bytes[0].data;
                    in_if.end_of_stream <= stream_bytes[0].eos;
                    in_pending = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                  : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 :
                                     ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                                  : $urandom_range(1, 6);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end

            if (sink_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(0, 3));
                sink_left = $urandom_range(40, 400);
            end
            sink_left--;
            sink_tick++;
            case (sink_mode)
                SINK_OPEN:     out_if.ready <= 1'b1;
                SINK_COIN:     out_if.ready <= 1'($urandom_range(0, 1));
                SINK_PERIODIC: out_if.ready <= (sink_tick % 7) < 2;
                default:       out_if.ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // Monitor: check results against the oldest due unit, then predict new bytes
    always @(posedge i_clk) begin : check_units
        t_access_unit want;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (due_units.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected unit: off=%0d len=%0d num=%0d t=%0d fin=%0b",
                                 out_if.unit_offset, out_if.unit_length, out_if.unit_number,
                                 out_if.unit_time_ns, out_if.unit_is_final);
                end else begin
                    want = due_units.pop_front();
                    if (out_if.unit_offset !== want.offset || out_if.unit_length !== want.length ||
                        out_if.unit_number !== want.number || out_if.unit_time_ns !== want.time_ns ||
                        out_if.unit_is_final !== want.is_final) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("unit mismatch, want: off=%0d len=%0d num=%0d t=%0d fin=%0b",
                                     want.offset, want.length, want.number,
                                     $signed(want.time_ns), want.is_final);
                            $display("                got: off=%0d len=%0d num=%0d t=%0d fin=%0b",
                                     out_if.unit_offset, out_if.unit_length, out_if.unit_number,
                                     out_if.unit_time_ns, out_if.unit_is_final);
                        end
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                scan_byte(in_if.data_byte, in_if.end_of_stream);
                void'(stream_bytes.pop_front());
                in_pending = 1'b0;
            end
        end
    end

    // Phases: reset rates with the opening stream, then each rate setting
    initial begin : run_phases
        logic [30:0] num;
        logic [30:0] den;
        in_if.valid         = 1'b0;
        in_if.data_byte     = '0;
        in_if.end_of_stream = 1'b0;
        out_if.ready        = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_RATE_NUM;
        i_cfg_data          = '0;
        i_rst_n             = 1'b0;
        rate_num            = RATE_NUM_RESET;
        rate_den            = RATE_DEN_RESET;
        clear_scanner();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (OPENING_SEQ[k]) push_byte(OPENING_SEQ[k][8], OPENING_SEQ[k][7:0]);
        queue_streams(BYTES_PER_PHASE - 25);
        wait_drained();

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            if (s < NUM_FIXED) begin
                num = FIXED_NUM[s];
                den = FIXED_DEN[s];
            end else begin
                num = 31'($urandom_range(1, RATE_MAX));
                den = 31'($urandom_range(1, RATE_MAX));
            end
            write_rate(CFG_RATE_NUM, num);
            write_rate(CFG_RATE_DEN, den);
            @(posedge i_clk);
            queue_streams(BYTES_PER_PHASE);
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### h264_access_unit_splitter.f
+incdir+rtl
rtl/h264aus_pkg.sv
rtl/h264aus_if.sv
rtl/h264aus_scanner.sv
rtl/h264aus_queue.sv
rtl/h264aus_timer.sv
rtl/h264_access_unit_splitter.sv
sim/tb_h264_access_unit_splitter.sv
